[src/tmla_pkg.sv]
`default_nettype none
package tmla_pkg;

  // Command codes carried in the input tuser
  typedef logic [1:0] func_t;
  localparam func_t FUNC_CLEAR = 2'd0;
  localparam func_t FUNC_LOAD  = 2'd1;
  localparam func_t FUNC_QUERY = 2'd2;

  // Fixed field widths
  localparam int KEY_W   = 20;
  localparam int BEST_W  = 20;
  localparam int TOTAL_W = 32;

  // Control part of a token moving down the cell chain
  typedef struct packed {
    logic  vld;
    func_t func;
    logic  drop;
  } ctl_t;

endpackage
`default_nettype wire

[src/threshold_max_lookup_accumulate_core.sv]
// A query transfer passes the MAX_JOBS cell registers, then the output register, before its result shows.
// Throughput: one item per cycle while the output does not stall; every command walks the chain of MAX_JOBS cells.
// A stalled output holds the whole chain and the input until the result is taken.
// Clear and load produce no result; an unused command is taken and discarded.
// Reset (rst_n low, synchronous) empties the table, zeroes the total and drop flag.
`default_nettype none
module threshold_max_lookup_accumulate_core #(
  parameter int MAX_JOBS   = 256,
  parameter int VALUE_BITS = 20
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [19:0] job_difficulty, [39:20] job_profit, [59:40] worker_ability
  input  wire [63:0]  in_tdata,
  // [1:0] func
  input  wire [1:0]   in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [19:0] best_profit, [51:20] running_total, [52] jobs_dropped
  output logic [55:0] out_tdata
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int KW    = tmla_pkg::KEY_W;

  // Head state: table fill count and sticky drop flag, both in program order
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             drop_r;
  logic             drop_nxt;
  logic             en;
  logic             acc;

  // Token links between cells; link 0 is the chain entry
  tmla_pkg::ctl_t         ctl_w [MAX_JOBS+1];
  logic [KW-1:0]          key_w [MAX_JOBS+1];
  logic [VALUE_BITS-1:0]  val_w [MAX_JOBS+1];
  logic [CNT_W-1:0]       cnt_w [MAX_JOBS+1];

  logic [KW-1:0]            in_diff;
  logic [KW-1:0]            in_thr;
  logic [VALUE_BITS+KW-1:0] prof_ext;
  tmla_pkg::func_t          func;

  assign in_diff   = in_tdata[19:0];
  assign prof_ext  = {{VALUE_BITS{1'b0}}, in_tdata[39:20]};
  assign in_thr    = in_tdata[59:40];
  assign func      = in_tuser;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  // Build the entry token and next head state
  always_comb begin
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    ctl_w[0].vld  = 1'b0;
    ctl_w[0].func = func;
    ctl_w[0].drop = drop_r;
    key_w[0]      = in_diff;
    val_w[0]      = '0;
    cnt_w[0]      = cnt_r;
    case (func)
      tmla_pkg::FUNC_CLEAR: begin
        ctl_w[0].vld  = acc;
        ctl_w[0].drop = 1'b0;
        cnt_nxt       = '0;
        drop_nxt      = 1'b0;
      end
      tmla_pkg::FUNC_LOAD: begin
        // slot index travels in the count field; full table drops the load
        val_w[0] = prof_ext[VALUE_BITS-1:0];
        if (cnt_r < CNT_W'(MAX_JOBS)) begin
          ctl_w[0].vld = acc;
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else begin
          drop_nxt = 1'b1;
        end
      end
      tmla_pkg::FUNC_QUERY: begin
        // threshold in key field, best-so-far starts at zero
        ctl_w[0].vld = acc;
        key_w[0]     = in_thr;
      end
      default: begin
        ctl_w[0].vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else if (acc) begin
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

  // One cell per table entry; tokens keep order, so each cell sees
  // commands in the order they were accepted.
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    tmla_cell #(
      .CELL_IDX   (i),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_w[i]),
      .key_i (key_w[i]),
      .val_i (val_w[i]),
      .cnt_i (cnt_w[i]),
      .ctl_o (ctl_w[i+1]),
      .key_o (key_w[i+1]),
      .val_o (val_w[i+1]),
      .cnt_o (cnt_w[i+1])
    );
  end

  // Tail: saturating total and output register
  tmla_acc #(
    .VALUE_BITS (VALUE_BITS)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .ctl_i      (ctl_w[MAX_JOBS]),
    .val_i      (val_w[MAX_JOBS]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

[src/tmla_cell.sv]
`default_nettype none
module tmla_cell #(
  parameter int CELL_IDX   = 0,
  parameter int VALUE_BITS = 20,
  parameter int CNT_W      = 9
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  tmla_pkg::ctl_t               ctl_i,
  input  wire [tmla_pkg::KEY_W-1:0]    key_i,
  input  wire [VALUE_BITS-1:0]         val_i,
  input  wire [CNT_W-1:0]              cnt_i,
  output tmla_pkg::ctl_t               ctl_o,
  output logic [tmla_pkg::KEY_W-1:0]   key_o,
  output logic [VALUE_BITS-1:0]        val_o,
  output logic [CNT_W-1:0]             cnt_o
);

  // Stored entry of this cell
  logic [tmla_pkg::KEY_W-1:0] key_r;
  logic [VALUE_BITS-1:0]      val_r;

  tmla_pkg::ctl_t             ctl_r;
  logic [tmla_pkg::KEY_W-1:0] tkey_r;
  logic [VALUE_BITS-1:0]      tval_r;
  logic [VALUE_BITS-1:0]      tval_nxt;
  logic [CNT_W-1:0]           tcnt_r;

  logic load_hit;
  logic qry_hit;

  // Load token carries its target slot in the count field;
  // query token carries the table size at issue and the best so far.
  assign load_hit = ctl_i.vld && (ctl_i.func == tmla_pkg::FUNC_LOAD) &&
                    (cnt_i == CNT_W'(CELL_IDX));
  assign qry_hit  = ctl_i.vld && (ctl_i.func == tmla_pkg::FUNC_QUERY) &&
                    (cnt_i > CNT_W'(CELL_IDX)) && (key_r <= key_i) && (val_r > val_i);
  assign tval_nxt = qry_hit ? val_r : val_i;

  always_ff @(posedge clk) begin
    if (en && load_hit) begin
      key_r <= key_i;
      val_r <= val_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tkey_r <= key_i;
      tval_r <= tval_nxt;
      tcnt_r <= cnt_i;
    end
  end

  assign ctl_o = ctl_r;
  assign key_o = tkey_r;
  assign val_o = tval_r;
  assign cnt_o = tcnt_r;

endmodule
`default_nettype wire

[src/tmla_acc.sv]
`default_nettype none
module tmla_acc #(
  parameter int VALUE_BITS = 20
) (
  input  wire                   clk,
  input  wire                   rst_n,
  output logic                  en,
  input  tmla_pkg::ctl_t        ctl_i,
  input  wire [VALUE_BITS-1:0]  val_i,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [55:0]           out_tdata
);

  localparam int TW = tmla_pkg::TOTAL_W;
  localparam int BW = tmla_pkg::BEST_W;

  logic          out_vld_r;
  logic [BW-1:0] best_r;
  logic [TW-1:0] total_r;
  logic [TW-1:0] total_nxt;
  logic          drop_r;
  logic [TW:0]   sum;
  logic [VALUE_BITS+BW-1:0] best_ext;
  logic          is_qry;
  logic          is_clr;

  // Whole chain moves when the output slot is free or being drained
  assign en = !out_vld_r || out_tready;

  assign is_qry   = ctl_i.vld && (ctl_i.func == tmla_pkg::FUNC_QUERY);
  assign is_clr   = ctl_i.vld && (ctl_i.func == tmla_pkg::FUNC_CLEAR);
  assign sum      = {1'b0, total_r} + (TW+1)'(val_i);
  assign best_ext = {{BW{1'b0}}, val_i};

  always_comb begin
    total_nxt = total_r;
    if (is_clr) begin
      total_nxt = '0;
    end else if (is_qry) begin
      total_nxt = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      total_r   <= '0;
    end else if (en) begin
      out_vld_r <= is_qry;
      total_r   <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && is_qry) begin
      best_r <= best_ext[BW-1:0];
      drop_r <= ctl_i.drop;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, drop_r, total_r, best_r};

endmodule
`default_nettype wire

[src/tmla_checker.sv]
`default_nettype none
module tmla_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [63:0] in_tdata,
  input wire [1:0]  in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [55:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_total_ge_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[51:20] >= {12'd0, out_tdata[19:0]}))
    else $error("total below current best");

endmodule

bind threshold_max_lookup_accumulate_core tmla_checker u_tmla_checker (.*);
`default_nettype wire

[bench/tmla_answer_check.sv]
`timescale 1ns / 100ps
// Watches both streams, predicts every query answer and compares it with
// the result that leaves the core.
module tmla_answer_check
  import tmla_pkg::*;
#(
  parameter int MAX_JOBS   = 256,
  parameter int VALUE_BITS = 20
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire [63:0]  in_tdata,
  input  wire [1:0]   in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire [55:0]  out_tdata,
  output int          mismatches,
  output int          outstanding
);

  // Same bit order as out_tdata: best in the low bits
  typedef struct packed {
    logic               dropped;
    logic [TOTAL_W-1:0] total;
    logic [BEST_W-1:0]  best;
  } answer_t;

  answer_t                answer_q[$];
  logic [KEY_W-1:0]       key_tab[MAX_JOBS];
  logic [VALUE_BITS-1:0]  val_tab[MAX_JOBS];
  int unsigned            n_entries;
  logic [TOTAL_W-1:0]     total_sum;
  logic                   dropped;
  int                     fails;

  // Max over every stored pair whose key passes, then saturating add
  function automatic answer_t answer_query(input logic [KEY_W-1:0] limit);
    logic [VALUE_BITS-1:0] best;
    logic [TOTAL_W:0]      sum;
    answer_t               a;
    best = '0;
    for (int i = 0; i < n_entries; i++) begin
      if (key_tab[i] <= limit && val_tab[i] > best) best = val_tab[i];
    end
    sum = {1'b0, total_sum} + (TOTAL_W + 1)'(best);
    if (sum[TOTAL_W]) sum = {1'b0, {TOTAL_W{1'b1}}};
    total_sum = sum[TOTAL_W-1:0];
    a.best    = BEST_W'(best);
    a.total   = total_sum;
    a.dropped = dropped;
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    answer_t got;
    if (!rst_n) begin
      n_entries = 0;
      total_sum = '0;
      dropped   = 1'b0;
      fails     = 0;
      answer_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        case (func_t'(in_tuser))
          FUNC_CLEAR: begin
            n_entries = 0;
            total_sum = '0;
            dropped   = 1'b0;
          end
          FUNC_LOAD: begin
            if (n_entries < MAX_JOBS) begin
              key_tab[n_entries] = in_tdata[19:0];
              val_tab[n_entries] = VALUE_BITS'(in_tdata[39:20]);
              n_entries++;
            end else begin
              dropped = 1'b1;
            end
          end
          FUNC_QUERY: answer_q.push_back(answer_query(in_tdata[59:40]));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = answer_t'(out_tdata[52:0]);
        if (answer_q.size() == 0) begin
          $error("result transfer with no query pending: %h", out_tdata);
          fails++;
        end else begin
          want = answer_q.pop_front();
          if (got.best !== want.best) begin
            $error("best_profit: expected %0h, got %0h", want.best, got.best);
            fails++;
          end
          if (got.total !== want.total) begin
            $error("running_total: expected %0h, got %0h", want.total, got.total);
            fails++;
          end
          if (got.dropped !== want.dropped) begin
            $error("jobs_dropped: expected %0b, got %0b", want.dropped, got.dropped);
            fails++;
          end
        end
      end
    end
    mismatches  <= fails;
    outstanding <= answer_q.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;
  import tmla_pkg::*;

  localparam int MAX_JOBS    = 256;
  localparam int VALUE_BITS  = 20;
  localparam int HOLD_CYCLES = 1000;
  localparam int PHASE_ITEMS = 380;
  localparam logic [19:0] FIELD_MAX = 20'hFFFFF;
  // func code the core takes and discards
  localparam func_t FUNC_SPARE = 2'd3;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  int mismatches;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_ticket    = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int items_sent     = 0;

  threshold_max_lookup_accumulate_core #(
    .MAX_JOBS   (MAX_JOBS),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tmla_answer_check #(
    .MAX_JOBS   (MAX_JOBS),
    .VALUE_BITS (VALUE_BITS)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  // While held, queries back up through the cell chain into in_tready.
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen  <= hold_ticket;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One transfer on the input, after a random number of idle cycles
  task automatic send_item(input func_t f, input logic [19:0] difficulty,
                           input logic [19:0] profit, input logic [19:0] ability);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {4'b0, ability, profit, difficulty};
    do @(posedge clk); while (!in_tready);
    if (f != FUNC_SPARE) items_sent++;
  endtask

  // Extremes, tight clusters (equal keys, keys next to thresholds) and noise
  function automatic logic [19:0] pick_field();
    case ($urandom_range(7))
      0:       return '0;
      1:       return FIELD_MAX;
      2, 3:    return 20'($urandom_range(15));
      4:       return 20'($urandom_range(20'hFFFF0, 20'hFFFFF));
      default: return 20'($urandom);
    endcase
  endfunction

  // Clear (mostly), a batch of loads, then queries with a few stray loads
  // and unused commands mixed in. A fill batch runs past the table size.
  task automatic play_sequence(input bit fill);
    int n_loads;
    int n_queries;
    if ($urandom_range(3) != 0) send_item(FUNC_CLEAR, pick_field(), pick_field(), pick_field());
    n_loads   = fill ? $urandom_range(MAX_JOBS + 2, MAX_JOBS + 14) : $urandom_range(0, 24);
    n_queries = $urandom_range(4, 30);
    repeat (n_loads) send_item(FUNC_LOAD, pick_field(), pick_field(), pick_field());
    repeat (n_queries) begin
      case ($urandom_range(19))
        0:       send_item(FUNC_SPARE, pick_field(), pick_field(), pick_field());
        1, 2:    send_item(FUNC_LOAD, pick_field(), pick_field(), pick_field());
        default: send_item(FUNC_QUERY, pick_field(), pick_field(), pick_field());
      endcase
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input bit fill, input bit hold);
    int stop_at;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    stop_at        = items_sent + PHASE_ITEMS;
    if (hold) hold_ticket <= hold_ticket + 1;
    if (fill) play_sequence(1'b1);
    while (items_sent < stop_at) play_sequence(1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, equal keys, threshold edges, unused command,
    // clear, and a key at the very top of the range
    send_item(FUNC_QUERY, '0, '0, FIELD_MAX);
    send_item(FUNC_LOAD, 20'h00000, 20'h00001, '0);
    send_item(FUNC_LOAD, 20'h80000, 20'h55555, '0);
    send_item(FUNC_LOAD, 20'h80000, 20'hAAAAA, '0);
    send_item(FUNC_LOAD, FIELD_MAX, FIELD_MAX, '0);
    send_item(FUNC_LOAD, 20'h12345, 20'h00000, '0);
    send_item(FUNC_QUERY, '0, '0, 20'h00000);
    send_item(FUNC_QUERY, '0, '0, 20'h7FFFF);
    send_item(FUNC_QUERY, '0, '0, 20'h80000);
    send_item(FUNC_QUERY, '0, '0, 20'hFFFFE);
    send_item(FUNC_QUERY, '0, '0, FIELD_MAX);
    send_item(FUNC_SPARE, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    send_item(FUNC_QUERY, '0, '0, 20'h80001);
    send_item(FUNC_CLEAR, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    send_item(FUNC_QUERY, FIELD_MAX, FIELD_MAX, 20'h00000);
    send_item(FUNC_LOAD, FIELD_MAX, 20'h00001, '0);
    send_item(FUNC_QUERY, '0, '0, 20'hFFFFE);
    send_item(FUNC_QUERY, '0, '0, FIELD_MAX);

    run_phase(0, 0, 1'b1, 1'b0);
    run_phase(60, 0, 1'b0, 1'b0);
    run_phase(0, 60, 1'b0, 1'b1);
    run_phase(24, 24, 1'b1, 1'b0);

    in_tvalid      <= 1'b0;
    recv_stall_pct = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (MAX_JOBS + 16) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
